/* src/envelope_waveform_oscillator_top_assert.svh */
// assertion macros for the envelope waveform oscillator top level
// expects clk_i and rst_ni in the including module
`ifndef ENVELOPE_WAVEFORM_OSCILLATOR_TOP_ASSERT_SVH
`define ENVELOPE_WAVEFORM_OSCILLATOR_TOP_ASSERT_SVH

// same-cycle implication
`define EWO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EWO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ewo_pkg.sv */
// shared types and constants of the envelope waveform oscillator
// no dependencies
package ewo_pkg;

  localparam int unsigned SAMPLE_RATE_HZ_DEF   = 48000;
  localparam int unsigned ENVELOPE_DEPTH_DEF   = 256;
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;

  localparam logic [2:0] REG_WAVEFORM       = 3'd0;
  localparam logic [2:0] REG_USE_INSTRUMENT = 3'd1;
  localparam logic [2:0] REG_VOLUME_LENGTH  = 3'd2;
  localparam logic [2:0] REG_PITCH_LENGTH   = 3'd3;
  localparam logic [2:0] REG_DUTY_LENGTH    = 3'd4;
  localparam logic [2:0] REG_DEFAULT_DUTY   = 3'd5;

  localparam logic [2:0] WAVE_SQUARE   = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [2:0] WAVE_SINE     = 3'd2;
  localparam logic [2:0] WAVE_SAWTOOTH = 3'd3;

  localparam logic [1:0] TSEL_VOLUME = 2'd0;
  localparam logic [1:0] TSEL_PITCH  = 2'd1;
  localparam logic [1:0] TSEL_DUTY   = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GEN  = 1'b1;

  localparam logic [15:0] DEFAULT_DUTY_RST = 16'd32768;
  localparam logic [8:0]  LENGTH_RST       = 9'd1;

  localparam logic [17:0] SIN_A = 18'd102944;
  localparam logic [17:0] SIN_B = 18'd42334;
  localparam logic [16:0] SIN_C = 17'd4926;

  localparam logic [1:0] POLY_C = 2'd0;
  localparam logic [1:0] POLY_B = 2'd1;
  localparam logic [1:0] POLY_A = 2'd2;

  typedef struct packed {
    logic       ld_entry;
    logic       start;
    logic       freq_en;
    logic       wave_en;
    logic       fold_en;
    logic       sq_en;
    logic       poly_en;
    logic [1:0] poly_op;
    logic       sine_en;
    logic       mul_en;
    logic       scale_en;
    logic       div5_en;
    logic       load_out;
  } ewo_ctl_t;

  typedef struct packed {
    logic acc_ok;
    logic sine_sel;
  } ewo_stat_t;

endpackage

/* src/ewo_cdiv.sv */
// divide by a constant: floor(val * 65536 / DIVISOR) for val below DIVISOR
// reciprocal multiply with one correction step, three register stages, free running
module ewo_cdiv #(
  parameter int unsigned DIVISOR = 96000
) (
  input  logic                         clk_i,
  input  logic [$clog2(DIVISOR)-1:0]   val_i,
  output logic [15:0]                  quo_o
);

  localparam int unsigned      Shift  = $clog2(DIVISOR);
  localparam longint unsigned  RecipL = (64'd1 << (16 + Shift)) / DIVISOR;
  localparam logic [16:0]      Recip  = 17'(RecipL);
  localparam logic [Shift+15:0] Div   = (Shift + 16)'(DIVISOR);

  logic [Shift+16:0] prod_q;
  logic [Shift-1:0]  val1_q;
  logic [Shift-1:0]  val2_q;
  logic [15:0]       qe_q;
  logic [Shift+15:0] qm_q;
  logic [15:0]       quo_q;
  logic [15:0]       qe_d;
  logic [Shift+15:0] rem;

  assign qe_d = prod_q[Shift+15:Shift];
  assign rem  = {val2_q, 16'h0000} - qm_q;

  always_ff @(posedge clk_i) begin
    prod_q <= (Shift + 17)'(val_i) * (Shift + 17)'(Recip);
    val1_q <= val_i;
    qe_q   <= qe_d;
    qm_q   <= (Shift + 16)'(qe_d) * Div;
    val2_q <= val1_q;
    quo_q  <= (rem >= Div) ? qe_q + 16'd1 : qe_q;
  end

  assign quo_o = quo_q;

endmodule

/* src/ewo_ctrl.sv */
// sequencer of the envelope waveform oscillator: handshakes and datapath commands
// uses ewo_pkg
module ewo_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ewo_pkg::ewo_stat_t  stat_i,
  output ewo_pkg::ewo_ctl_t   ctl_o
);
  import ewo_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_FREQ = 5'd1;
  localparam logic [4:0] ST_DIV  = 5'd2;
  localparam logic [4:0] ST_WAVE = 5'd3;
  localparam logic [4:0] ST_SW0  = 5'd4;
  localparam logic [4:0] ST_SW1  = 5'd5;
  localparam logic [4:0] ST_SW2  = 5'd6;
  localparam logic [4:0] ST_FOLD = 5'd7;
  localparam logic [4:0] ST_SQR  = 5'd8;
  localparam logic [4:0] ST_PC   = 5'd9;
  localparam logic [4:0] ST_PB   = 5'd10;
  localparam logic [4:0] ST_PA   = 5'd11;
  localparam logic [4:0] ST_SINW = 5'd12;
  localparam logic [4:0] ST_MUL  = 5'd13;
  localparam logic [4:0] ST_SCL  = 5'd14;
  localparam logic [4:0] ST_DIV5 = 5'd15;
  localparam logic [4:0] ST_DONE = 5'd16;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    ctl_o          = '0;
    state_d        = state_q;
    ctl_o.ld_entry = accept && (cmd_i == CMD_LOAD);
    ctl_o.start    = accept && (cmd_i == CMD_GEN);
    case (state_q)
      ST_IDLE: begin
        if (ctl_o.start) state_d = ST_FREQ;
      end
      ST_FREQ: begin
        ctl_o.freq_en = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV:  state_d = ST_WAVE;
      ST_WAVE: begin
        ctl_o.wave_en = 1'b1;
        state_d       = stat_i.sine_sel ? ST_SW0 : ST_MUL;
      end
      ST_SW0:  state_d = ST_SW1;
      ST_SW1:  state_d = ST_SW2;
      ST_SW2:  state_d = ST_FOLD;
      ST_FOLD: begin
        ctl_o.fold_en = 1'b1;
        state_d       = ST_SQR;
      end
      ST_SQR: begin
        ctl_o.sq_en = 1'b1;
        state_d     = ST_PC;
      end
      ST_PC: begin
        ctl_o.poly_en = 1'b1;
        ctl_o.poly_op = POLY_C;
        state_d       = ST_PB;
      end
      ST_PB: begin
        ctl_o.poly_en = 1'b1;
        ctl_o.poly_op = POLY_B;
        state_d       = ST_PA;
      end
      ST_PA: begin
        ctl_o.poly_en = 1'b1;
        ctl_o.poly_op = POLY_A;
        state_d       = ST_SINW;
      end
      ST_SINW: begin
        ctl_o.sine_en = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        ctl_o.mul_en = 1'b1;
        state_d      = ST_SCL;
      end
      ST_SCL: begin
        ctl_o.scale_en = 1'b1;
        state_d        = ST_DIV5;
      end
      ST_DIV5: begin
        ctl_o.div5_en = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.acc_ok && out_free) begin
          ctl_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* src/ewo_dp.sv */
// datapath of the envelope waveform oscillator: registers, envelope memories,
// phase accumulator, waveform shaping and output scaling; uses ewo_pkg and ewo_cdiv
module ewo_dp #(
  parameter int unsigned SAMPLE_RATE_HZ   = ewo_pkg::SAMPLE_RATE_HZ_DEF,
  parameter int unsigned ENVELOPE_DEPTH   = ewo_pkg::ENVELOPE_DEPTH_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = ewo_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [1:0]          table_select_i,
  input  logic [7:0]          entry_index_i,
  input  logic [15:0]         entry_value_i,
  input  logic [15:0]         frequency_i,
  input  logic [7:0]          frame_i,
  input  ewo_pkg::ewo_ctl_t   ctl_i,
  output ewo_pkg::ewo_stat_t  stat_o,
  output logic signed [15:0]  sample_o
);
  import ewo_pkg::*;

  localparam int unsigned PhaseMod = 2 * SAMPLE_RATE_HZ;
  localparam int unsigned PhaseW   = $clog2(PhaseMod);
  localparam int unsigned AccW     = ((PhaseW > 16) ? PhaseW : 16) + 1;
  localparam int unsigned EnvAw    = (ENVELOPE_DEPTH > 1) ? $clog2(ENVELOPE_DEPTH) : 1;
  localparam int unsigned SineW    = $clog2(SINE_TABLE_DEPTH);
  localparam logic [AccW-1:0] ModA = AccW'(PhaseMod);

  function automatic logic [EnvAw-1:0] env_addr(input logic [7:0] frame,
                                                input logic [8:0] len);
    logic [8:0] last;
    logic [8:0] pos;
    last = (len == 9'd0) ? 9'd0 : len - 9'd1;
    pos  = ({1'b0, frame} < last) ? {1'b0, frame} : last;
    if (pos >= 9'(ENVELOPE_DEPTH)) pos = 9'(ENVELOPE_DEPTH - 1);
    return pos[EnvAw-1:0];
  endfunction

  // configuration registers
  logic [2:0]  waveform_q;
  logic        use_inst_q;
  logic [8:0]  vol_len_q, pitch_len_q, duty_len_q;
  logic [15:0] default_duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q     <= WAVE_SQUARE;
      use_inst_q     <= 1'b0;
      vol_len_q      <= LENGTH_RST;
      pitch_len_q    <= LENGTH_RST;
      duty_len_q     <= LENGTH_RST;
      default_duty_q <= DEFAULT_DUTY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WAVEFORM:       waveform_q     <= cfg_data_i[2:0];
        REG_USE_INSTRUMENT: use_inst_q     <= cfg_data_i[0];
        REG_VOLUME_LENGTH:  vol_len_q      <= cfg_data_i[8:0];
        REG_PITCH_LENGTH:   pitch_len_q    <= cfg_data_i[8:0];
        REG_DUTY_LENGTH:    duty_len_q     <= cfg_data_i[8:0];
        REG_DEFAULT_DUTY:   default_duty_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // envelope memories
  logic [15:0] vol_mem   [ENVELOPE_DEPTH];
  logic [15:0] pitch_mem [ENVELOPE_DEPTH];
  logic [15:0] duty_mem  [ENVELOPE_DEPTH];
  logic [15:0] vol_rd_q, pitch_rd_q, duty_rd_q;
  logic        entry_ok;
  logic [EnvAw-1:0] waddr;

  assign entry_ok = ctl_i.ld_entry && ({1'b0, entry_index_i} < 9'(ENVELOPE_DEPTH));
  assign waddr    = entry_index_i[EnvAw-1:0];

  always_ff @(posedge clk_i) begin
    if (entry_ok && (table_select_i == TSEL_VOLUME)) vol_mem[waddr] <= entry_value_i;
    if (ctl_i.start) vol_rd_q <= vol_mem[env_addr(frame_i, vol_len_q)];
  end

  always_ff @(posedge clk_i) begin
    if (entry_ok && (table_select_i == TSEL_PITCH)) pitch_mem[waddr] <= entry_value_i;
    if (ctl_i.start) pitch_rd_q <= pitch_mem[env_addr(frame_i, pitch_len_q)];
  end

  always_ff @(posedge clk_i) begin
    if (entry_ok && (table_select_i == TSEL_DUTY)) duty_mem[waddr] <= entry_value_i;
    if (ctl_i.start) duty_rd_q <= duty_mem[env_addr(frame_i, duty_len_q)];
  end

  // frequency and phase
  logic [15:0]       base_q;
  logic [15:0]       freq;
  logic signed [17:0] fsum;
  logic [16:0]       vol_q;
  logic [15:0]       duty_q;
  logic [AccW-1:0]   acc_q;
  logic [PhaseW-1:0] phase_q;

  assign fsum = $signed({2'b00, base_q}) + $signed({{2{pitch_rd_q[15]}}, pitch_rd_q});

  always_comb begin
    freq = base_q;
    if (use_inst_q) begin
      if (fsum[17]) begin
        freq = 16'd0;
      end else if (fsum[16]) begin
        freq = 16'hFFFF;
      end else begin
        freq = fsum[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) base_q <= frequency_i;
    if (ctl_i.freq_en) begin
      vol_q  <= use_inst_q ? {1'b0, vol_rd_q} : 17'h10000;
      duty_q <= use_inst_q ? duty_rd_q : default_duty_q;
      acc_q  <= AccW'(phase_q) + AccW'(freq);
    end else if (acc_q >= ModA) begin
      acc_q  <= acc_q - ModA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (ctl_i.load_out) begin
      phase_q <= acc_q[PhaseW-1:0];
    end
  end

  logic [15:0] p16;

  ewo_cdiv #(
    .DIVISOR (PhaseMod)
  ) u_phase_div (
    .clk_i (clk_i),
    .val_i (phase_q),
    .quo_o (p16)
  );

  // waveform shaping
  logic signed [17:0] tri_d;
  logic [17:0]        tri_abs;
  logic signed [15:0] tri_w;
  logic signed [16:0] saw_s;
  logic signed [18:0] saw_t;
  logic signed [18:0] saw_b;
  logic signed [15:0] saw_w;
  logic signed [15:0] sq_w;
  logic [31:0]        idx_prod;
  logic [SineW-1:0]   idx_q;
  logic signed [15:0] w_q;

  assign tri_d   = $signed({1'b0, p16, 1'b0}) - 18'sd65536;
  assign tri_abs = tri_d[17] ? 18'(-tri_d) : 18'(tri_d);
  assign tri_w   = tri_abs[16] ? 16'sd32767 : $signed({~tri_abs[15], tri_abs[14:0]});
  assign saw_s   = $signed({1'b0, p16}) - 17'sd32768;
  assign saw_t   = (19'(saw_s) <<< 1) + 19'(saw_s);
  assign saw_b   = saw_t + (saw_t[18] ? 19'sd3 : 19'sd0);
  assign saw_w   = 16'(saw_b >>> 2);
  assign sq_w    = (p16 < duty_q) ? 16'sd16384 : -16'sd16384;
  assign idx_prod = 32'(p16) * 32'(SINE_TABLE_DEPTH);

  // sine quarter-wave polynomial
  logic [15:0] a16;
  logic [15:0] xr;
  logic [16:0] x_q;
  logic        sneg_q;
  logic [33:0] xx;
  logic [16:0] x2_q;
  logic [33:0] p_q;
  logic [17:0] t_b;
  logic [17:0] t_a;
  logic [16:0] y;
  logic [15:0] ycap;

  ewo_cdiv #(
    .DIVISOR (SINE_TABLE_DEPTH)
  ) u_sine_div (
    .clk_i (clk_i),
    .val_i (idx_q),
    .quo_o (a16)
  );

  assign xr   = {a16[13:0], 2'b00};
  assign xx   = 34'(x_q) * 34'(x_q);
  assign t_b  = SIN_B - p_q[33:16];
  assign t_a  = SIN_A - p_q[33:16];
  assign y    = p_q[33:17];
  assign ycap = (y > 17'd32767) ? 16'd32767 : y[15:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wave_en) begin
      idx_q <= idx_prod[16 +: SineW];
      case (waveform_q)
        WAVE_SQUARE:   w_q <= sq_w;
        WAVE_TRIANGLE: w_q <= tri_w;
        WAVE_SAWTOOTH: w_q <= saw_w;
        default:       w_q <= 16'sd0;
      endcase
    end else if (ctl_i.sine_en) begin
      w_q <= sneg_q ? -$signed(ycap) : $signed(ycap);
    end
    if (ctl_i.fold_en) begin
      x_q    <= a16[14] ? 17'h10000 - {1'b0, xr} : {1'b0, xr};
      sneg_q <= a16[15];
    end
    if (ctl_i.sq_en) x2_q <= xx[32:16];
    if (ctl_i.poly_en) begin
      case (ctl_i.poly_op)
        POLY_C:  p_q <= 34'(x2_q) * 34'(SIN_C);
        POLY_B:  p_q <= 34'(x2_q) * 34'(t_b[15:0]);
        POLY_A:  p_q <= 34'(x_q) * 34'(t_a[16:0]);
        default: p_q <= p_q;
      endcase
    end
  end

  // volume and 0.2 * 32767 / 32768 scaling, truncated toward zero
  logic signed [33:0] wv_q;
  logic signed [48:0] num;
  logic [48:0]        mag;
  logic [14:0]        u_q;
  logic               neg_q;
  logic [30:0]        m5_q;
  logic [15:0]        q5;
  logic signed [15:0] sample_q;

  assign num = (49'(wv_q) <<< 15) - 49'(wv_q);
  assign mag = num[48] ? 49'(-num) : 49'(num);
  assign q5  = {3'b000, m5_q[30:18]};

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) wv_q <= 34'(w_q) * 34'($signed({2'b00, vol_q}));
    if (ctl_i.scale_en) begin
      u_q   <= mag[45:31];
      neg_q <= num[48];
    end
    if (ctl_i.div5_en) m5_q <= 31'(u_q) * 31'(16'd52429);
    if (ctl_i.load_out) sample_q <= neg_q ? -$signed(q5) : $signed(q5);
  end

  assign sample_o        = sample_q;
  assign stat_o.acc_ok   = (acc_q < ModA);
  assign stat_o.sine_sel = (waveform_q == WAVE_SINE);

endmodule

/* src/envelope_waveform_oscillator_top.sv */
// envelope waveform oscillator top level: sequencer plus datapath, uses ewo_pkg
// load request: accepted only when idle, no result, the block stays idle
// sample request: states FREQ, DIV, WAVE, MUL, SCL, DIV5, DONE (sine adds the divider wait,
//   the fold, the four-step polynomial and the sine write after WAVE), result registered
//   on leaving DONE, which waits while a pending result stays stalled, and also on the phase
//   wrap, which can only hold it at a sample rate under 6554 Hz; no new request meanwhile
// reset: registers to their defaults, phase to zero, envelope memories not cleared
module envelope_waveform_oscillator_top #(
  parameter int unsigned SAMPLE_RATE_HZ   = ewo_pkg::SAMPLE_RATE_HZ_DEF,
  parameter int unsigned ENVELOPE_DEPTH   = ewo_pkg::ENVELOPE_DEPTH_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = ewo_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [1:0]         table_select_i,
  input  logic [7:0]         entry_index_i,
  input  logic [15:0]        entry_value_i,
  input  logic [15:0]        frequency_i,
  input  logic [7:0]         frame_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_o
);
  import ewo_pkg::*;

  ewo_ctl_t  ctl;
  ewo_stat_t stat;

  ewo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  ewo_dp #(
    .SAMPLE_RATE_HZ   (SAMPLE_RATE_HZ),
    .ENVELOPE_DEPTH   (ENVELOPE_DEPTH),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .table_select_i (table_select_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .frequency_i    (frequency_i),
    .frame_i        (frame_i),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .sample_o       (sample_o)
  );

`include "envelope_waveform_oscillator_top_assert.svh"

  `EWO_ASSERT_NEXT(a_busy_after_gen, in_valid_i && !in_stall_o && (cmd_i == CMD_GEN), in_stall_o, "sample request did not make the block busy")
  `EWO_ASSERT_NOW(a_load_needs_wrap, ctl.load_out, stat.acc_ok, "phase stored before wrap finished")
  `EWO_ASSERT_NOW(a_load_needs_room, ctl.load_out, !out_valid_o || !out_stall_i, "result overwrote a pending result")
  `EWO_ASSERT_NEXT(a_valid_from_load, !out_valid_o && !ctl.load_out, !out_valid_o, "result appeared without a load")

endmodule

/* dv/envelope_waveform_oscillator_top_tb.sv */
// self-checking testbench for envelope_waveform_oscillator_top: directed and random requests
// with a sample scoreboard that predicts every generated sample; depends on ewo_pkg and the RTL
module envelope_waveform_oscillator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ewo_pkg::*;

  localparam longint PHASE_MOD  = 2 * longint'(SAMPLE_RATE_HZ_DEF);
  localparam longint ENV_DEPTH  = longint'(ENVELOPE_DEPTH_DEF);
  localparam longint SINE_DEPTH = longint'(SINE_TABLE_DEPTH_DEF);

  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;
  localparam logic [2:0] WAVE_NOISE    = 3'd4;
  localparam logic [1:0] TSEL_NONE     = 2'd3;

  class sample_scoreboard;
    logic [2:0]         wave_sel;
    logic               instrument_on;
    logic [8:0]         vol_len;
    logic [8:0]         pitch_len;
    logic [8:0]         duty_len;
    logic [15:0]        duty_default;
    longint             phase_acc;
    logic [15:0]        vol_table [ENV_DEPTH];
    logic [15:0]        pitch_table [ENV_DEPTH];
    logic [15:0]        duty_table [ENV_DEPTH];
    logic signed [15:0] expected_samples [$];
    int                 errors;

    function new();
      wave_sel      = WAVE_SQUARE;
      instrument_on = 1'b0;
      vol_len       = LENGTH_RST;
      pitch_len     = LENGTH_RST;
      duty_len      = LENGTH_RST;
      duty_default  = DEFAULT_DUTY_RST;
      phase_acc     = 0;
      errors        = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_WAVEFORM:       wave_sel = data[2:0];
        REG_USE_INSTRUMENT: instrument_on = data[0];
        REG_VOLUME_LENGTH:  vol_len = data[8:0];
        REG_PITCH_LENGTH:   pitch_len = data[8:0];
        REG_DUTY_LENGTH:    duty_len = data[8:0];
        REG_DEFAULT_DUTY:   duty_default = data;
        default: ;
      endcase
    endfunction

    function int entry_slot(logic [7:0] frm, logic [8:0] len);
      longint last;
      longint slot;
      last = (len == 0) ? 0 : longint'(len) - 1;
      slot = (longint'(frm) < last) ? longint'(frm) : last;
      if (slot >= ENV_DEPTH) slot = ENV_DEPTH - 1;
      return int'(slot);
    endfunction

    function longint sine_level(longint p16);
      longint idx, a16, q, x, x2, t, t2, y;
      idx = (p16 * SINE_DEPTH) >> 16;
      a16 = (idx * 65536) / SINE_DEPTH;
      q   = (a16 >> 14) & 3;
      x   = (a16 & 'h3FFF) << 2;
      if (q & 1) x = 65536 - x;
      x2 = (x * x) >> 16;
      t  = longint'(SIN_B) - ((x2 * longint'(SIN_C)) >> 16);
      t2 = longint'(SIN_A) - ((x2 * t) >> 16);
      y  = ((x * t2) >> 16) >> 1;
      if (y > 32767) y = 32767;
      return (q & 2) ? -y : y;
    endfunction

    function void note_request(logic cmd, logic [1:0] sel, logic [7:0] idx, logic [15:0] val,
                               logic [15:0] base, logic [7:0] frm);
      longint vol, duty, freq, offset, p16, w, d, num, res;
      if (cmd == CMD_LOAD) begin
        case (sel)
          TSEL_VOLUME: vol_table[idx] = val;
          TSEL_PITCH:  pitch_table[idx] = val;
          TSEL_DUTY:   duty_table[idx] = val;
          default: ;
        endcase
        return;
      end
      vol  = 65536;
      duty = longint'(duty_default);
      freq = longint'(base);
      if (instrument_on) begin
        offset = longint'($signed(pitch_table[entry_slot(frm, pitch_len)]));
        vol    = longint'(vol_table[entry_slot(frm, vol_len)]);
        duty   = longint'(duty_table[entry_slot(frm, duty_len)]);
        freq   = freq + offset;
        if (freq < 0) freq = 0;
        if (freq > 65535) freq = 65535;
      end
      p16 = (phase_acc << 16) / PHASE_MOD;
      case (wave_sel)
        WAVE_SQUARE: w = (phase_acc * 65536 < duty * PHASE_MOD) ? 16384 : -16384;
        WAVE_TRIANGLE: begin
          d = 2 * p16 - 65536;
          if (d < 0) d = -d;
          w = d - 32768;
          if (w > 32767) w = 32767;
        end
        WAVE_SINE:     w = sine_level(p16);
        WAVE_SAWTOOTH: w = (3 * (p16 - 32768)) / 4;
        default:       w = 0;
      endcase
      num = w * vol * 32767;
      res = num / (longint'(32768) * 65536 * 5);
      expected_samples.push_back(res[15:0]);
      phase_acc = (phase_acc + freq) % PHASE_MOD;
    endfunction

    function void check_sample(logic signed [15:0] actual);
      logic signed [15:0] want;
      if (expected_samples.size() == 0) begin
        $error("sample: unexpected result, expected none, actual %0d", actual);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      if (actual !== want) begin
        $error("sample: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [2:0]         cfg_index_i    = '0;
  logic [15:0]        cfg_data_i     = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic               cmd_i          = CMD_LOAD;
  logic [1:0]         table_select_i = '0;
  logic [7:0]         entry_index_i  = '0;
  logic [15:0]        entry_value_i  = '0;
  logic [15:0]        frequency_i    = '0;
  logic [7:0]         frame_i        = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic signed [15:0] sample_o;

  sample_scoreboard sb = new();
  bit entry_loaded [3][ENV_DEPTH];
  int send_pct       = 13;
  int recv_pct       = 71;
  int accepted_total = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  envelope_waveform_oscillator_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .table_select_i (table_select_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .frequency_i    (frequency_i),
    .frame_i        (frame_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_o       (sample_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) sb.check_sample(sample_o);
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        sb.note_request(cmd_i, table_select_i, entry_index_i, entry_value_i, frequency_i,
                        frame_i);
        accepted_total++;
      end
    end
  end

  // receiver side, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && accepted_total >= 150) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_pct);
    end
  end

  task automatic offer_request(logic cmd, logic [1:0] sel, logic [7:0] idx, logic [15:0] val,
                               logic [15:0] freq, logic [7:0] frm);
    while ($urandom_range(99) < send_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    table_select_i <= sel;
    entry_index_i  <= idx;
    entry_value_i  <= val;
    frequency_i    <= freq;
    frame_i        <= frm;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic load_entry(logic [1:0] sel, logic [7:0] idx, logic [15:0] val);
    if (sel == TSEL_VOLUME || sel == TSEL_PITCH || sel == TSEL_DUTY) entry_loaded[sel][idx] = 1'b1;
    offer_request(CMD_LOAD, sel, idx, val, 16'($urandom), 8'($urandom));
  endtask

  // with the instrument on, envelope entries that this sample reads and that are not yet loaded get loaded first
  task automatic gen_sample(logic [15:0] freq, logic [7:0] frm);
    int slot;
    if (sb.instrument_on) begin
      slot = sb.entry_slot(frm, sb.vol_len);
      if (!entry_loaded[TSEL_VOLUME][slot])
        load_entry(TSEL_VOLUME, 8'(slot), 16'($urandom_range(65535)));
      slot = sb.entry_slot(frm, sb.pitch_len);
      if (!entry_loaded[TSEL_PITCH][slot])
        load_entry(TSEL_PITCH, 8'(slot), 16'($urandom_range(65535)));
      slot = sb.entry_slot(frm, sb.duty_len);
      if (!entry_loaded[TSEL_DUTY][slot])
        load_entry(TSEL_DUTY, 8'(slot), 16'($urandom_range(65535)));
    end
    offer_request(CMD_GEN, 2'($urandom_range(3)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), freq, frm);
  endtask

  task automatic random_request();
    logic [15:0] freq;
    logic [7:0]  frm;
    if ($urandom_range(99) < 20) begin
      load_entry(2'($urandom_range(3)), 8'($urandom_range(255)), 16'($urandom_range(65535)));
    end else begin
      case ($urandom_range(9))
        0:       freq = 16'($urandom_range(3));
        1:       freq = 16'($urandom_range(65535, 65532));
        default: freq = 16'($urandom_range(65535));
      endcase
      frm = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
      gen_sample(freq, frm);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_samples(int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_samples.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_length(int sel);
    case (sel % 6)
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd256;
      3:       return 16'd511;
      4:       return 16'($urandom_range(256, 1));
      default: return 16'($urandom_range(12, 2));
    endcase
  endfunction

  function automatic logic [15:0] pick_duty(int sel);
    case (sel % 4)
      0:       return 16'd0;
      1:       return 16'd65535;
      2:       return 16'd32768;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: square at default duty, no instrument
    gen_sample(16'd0, 8'd0);
    gen_sample(16'd65535, 8'd255);
    gen_sample(16'd48000, 8'd0);
    gen_sample(16'd1, 8'd128);
    load_entry(TSEL_VOLUME, 8'd0, 16'hFFFF);
    load_entry(TSEL_PITCH, 8'd0, 16'h8000);
    load_entry(TSEL_DUTY, 8'd0, 16'h0000);
    load_entry(TSEL_NONE, 8'd0, 16'h5555);
    load_entry(TSEL_VOLUME, 8'd255, 16'hFFFF);
    load_entry(TSEL_PITCH, 8'd255, 16'h7FFF);
    load_entry(TSEL_DUTY, 8'd255, 16'hFFFF);

    // most negative pitch saturates to zero, zero duty
    drain_samples(24);
    write_reg(REG_USE_INSTRUMENT, 16'd1);
    end_writes();
    gen_sample(16'd100, 8'd37);

    // last entry: positive pitch saturates high, full duty
    drain_samples(24);
    write_reg(REG_VOLUME_LENGTH, 16'd256);
    write_reg(REG_PITCH_LENGTH, 16'd256);
    write_reg(REG_DUTY_LENGTH, 16'd256);
    write_reg(REG_DEFAULT_DUTY, 16'd0);
    end_writes();
    gen_sample(16'd65535, 8'd255);
    gen_sample(16'd65535, 8'd255);

    drain_samples(24);
    write_reg(REG_WAVEFORM, 16'(WAVE_TRIANGLE));
    write_reg(REG_USE_INSTRUMENT, 16'd0);
    write_reg(REG_DEFAULT_DUTY, 16'd65535);
    end_writes();
    gen_sample(16'd24000, 8'd3);
    gen_sample(16'd24000, 8'd3);

    drain_samples(24);
    write_reg(REG_WAVEFORM, 16'(WAVE_SINE));
    end_writes();
    gen_sample(16'd12000, 8'd0);
    gen_sample(16'd12000, 8'd0);

    drain_samples(24);
    write_reg(REG_WAVEFORM, 16'(WAVE_SAWTOOTH));
    end_writes();
    gen_sample(16'd30000, 8'd0);
    gen_sample(16'd30000, 8'd0);

    drain_samples(24);
    write_reg(REG_WAVEFORM, 16'(WAVE_NOISE));
    end_writes();
    gen_sample(16'd777, 8'd0);

    for (int k = 0; k < 12; k++) begin
      drain_samples(24);
      write_reg(REG_WAVEFORM, 16'(k % 8));
      write_reg(REG_USE_INSTRUMENT, 16'((k < 8) ? (k % 2 == 0) : (k % 2 == 1)));
      write_reg(REG_VOLUME_LENGTH, pick_length(k));
      write_reg(REG_PITCH_LENGTH, pick_length(k + 2));
      write_reg(REG_DUTY_LENGTH, pick_length(k + 4));
      write_reg(REG_DEFAULT_DUTY, pick_duty(k));
      if (k == 0) begin
        write_reg(REG_UNUSED_LO, 16'($urandom_range(65535)));
        write_reg(REG_UNUSED_HI, 16'($urandom_range(65535)));
      end
      case (k / 4)
        0: begin
          send_pct = 13;
          recv_pct = 71;
        end
        1: begin
          send_pct = 71;
          recv_pct = 13;
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      end_writes();
      for (int n = 0; n < 40; n++) begin
        if (k == 5 && n == 20) drain_samples(0);
        random_request();
      end
    end

    drain_samples(40);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
